// ----- hw/rtl/lcdns_pkg.sv -----
// Shared types, codes and constants of the character LCD nibble sequencer.
package lcdns_pkg;

  localparam int unsigned ReqW     = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NibW     = 4;
  localparam int unsigned RowW     = 1;
  localparam int unsigned ColW     = 6;
  localparam int unsigned RowsW    = 2;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned PhaseW   = 4;
  localparam int unsigned StepW    = 4;

  // Request / active operation codes
  typedef enum logic [ReqW-1:0] {
    OP_IDLE  = 3'd0,
    OP_INIT  = 3'd1,
    OP_CMD   = 3'd2,
    OP_DATA  = 3'd3,
    OP_GOTO  = 3'd4,
    OP_CLEAR = 3'd5
  } op_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROWS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COLS = 1'b1;

  localparam logic [RowsW-1:0] ROWS_RESET = 2'd2;
  localparam logic [ColW-1:0]  COLS_RESET = 6'd16;

  // Byte transfer phases
  localparam logic [PhaseW-1:0] PH_HIGH = 4'd1;
  localparam logic [PhaseW-1:0] PH_LOW  = 4'd3;
  localparam logic [PhaseW-1:0] PH_CMD_END  = 4'd5;
  localparam logic [PhaseW-1:0] PH_DATA_END = 4'd8;

  // Init sequence steps: power-up pulse, three waits, seven commands, finish
  localparam logic [StepW-1:0] INIT_WAIT_LAST = 4'd3;
  localparam logic [StepW-1:0] INIT_CMD_FIRST = 4'd4;
  localparam logic [StepW-1:0] INIT_CMD_LAST  = 4'd10;

  // Clear sequence steps
  localparam logic [StepW-1:0] CLR_FIRST  = 4'd0;
  localparam logic [StepW-1:0] CLR_SECOND = 4'd1;
  localparam logic [StepW-1:0] CLR_FINISH = 4'd2;

  localparam logic [ByteW-1:0] CLR_BYTE_A = 8'h00;
  localparam logic [ByteW-1:0] CLR_BYTE_B = 8'h01;

  function automatic logic [ByteW-1:0] init_byte(logic [2:0] idx);
    logic [ByteW-1:0] b;
    unique case (idx)
      3'd0:    b = 8'h20;
      3'd1:    b = 8'h20;
      3'd2:    b = 8'h80;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'hC0;
      3'd5:    b = 8'h00;
      default: b = 8'h10;
    endcase
    return b;
  endfunction

  typedef struct packed {
    logic            en;
    logic            rs;
    logic            rw;
    logic [NibW-1:0] nib;
  } pins_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [StepW-1:0]  step;
    op_e               op;
    logic [ByteW-1:0]  held;
    logic              configured;
    pins_t             pins;
  } state_t;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [ByteW-1:0] byte_value;
    logic [RowW-1:0]  row_index;
    logic [ColW-1:0]  col_index;
  } req_t;

  typedef struct packed {
    pins_t pins;
    logic  busy;
    logic  done;
    logic  rejected;
  } res_t;

endpackage

// ----- hw/rtl/lcdns_if.sv -----
// Valid/ready channel interfaces for requests, results and register writes.
interface lcdns_req_if import lcdns_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ReqW-1:0]  req_type;
  logic [ByteW-1:0] byte_value;
  logic [RowW-1:0]  row_index;
  logic [ColW-1:0]  col_index;

  modport source (output valid, req_type, byte_value, row_index, col_index, input ready);
  modport sink   (input valid, req_type, byte_value, row_index, col_index, output ready);
endinterface

interface lcdns_res_if import lcdns_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            pin_enable;
  logic            pin_select;
  logic            pin_readwrite;
  logic [NibW-1:0] pin_nibble;
  logic            busy_res;
  logic            done_res;
  logic            rejected;

  modport source (output valid, pin_enable, pin_select, pin_readwrite, pin_nibble,
                  busy_res, done_res, rejected, input ready);
  modport sink   (input valid, pin_enable, pin_select, pin_readwrite, pin_nibble,
                  busy_res, done_res, rejected, output ready);
endinterface

interface lcdns_cfg_if import lcdns_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/lcdns_step.sv -----
// One tick of the sequencer: request decode, phase advance and pin update.
module lcdns_step import lcdns_pkg::*; (
  input  state_t           state_i,
  input  req_t             req_i,
  input  logic [RowsW-1:0] rows_i,
  input  logic [ColW-1:0]  cols_i,
  output state_t           state_o,
  output res_t             res_o
);

  typedef struct packed {
    state_t st;
    logic   fin;
  } tick_t;

  function automatic tick_t byte_tick(state_t s, logic [ByteW-1:0] b, logic rs);
    tick_t r;
    logic [PhaseW-1:0] p;
    r.st  = s;
    r.fin = 1'b0;
    p     = s.phase + 4'd1;
    r.st.phase = p;
    if (p == PH_HIGH) begin
      r.st.pins.rw  = 1'b0;
      r.st.pins.rs  = rs;
      r.st.pins.nib = b[7:4];
      r.st.pins.en  = 1'b0;
    end else if (p == PH_LOW) begin
      // Before init completes a command sends its high nibble only
      if (rs || s.configured) begin
        r.st.pins.nib = b[3:0];
        r.st.pins.en  = 1'b0;
      end else begin
        r.st.pins.en = 1'b1;
      end
    end else if (p == PH_CMD_END) begin
      r.st.pins.en = 1'b1;
      if (!rs) begin
        r.st.phase = '0;
        r.fin      = 1'b1;
      end
    end else if (p >= PH_DATA_END) begin
      r.st.phase = '0;
      r.fin      = 1'b1;
    end
    return r;
  endfunction

  logic  is_req;
  logic  out_of_range;
  tick_t t;
  logic [ByteW-1:0] init_b;

  always_comb begin
    state_o      = state_i;
    res_o        = '0;
    t            = '0;
    is_req       = (req_i.req_type >= OP_INIT) && (req_i.req_type <= OP_CLEAR);
    out_of_range = ({1'b0, req_i.row_index} >= rows_i) || (req_i.col_index >= cols_i);
    init_b       = init_byte(3'(state_i.step - INIT_CMD_FIRST));

    // Start a request only when idle; go-to must land on the display
    if (is_req) begin
      if (state_i.op != OP_IDLE) begin
        res_o.rejected = 1'b1;
      end else if ((req_i.req_type == OP_GOTO) && out_of_range) begin
        res_o.rejected = 1'b1;
      end else begin
        state_o.op    = op_e'(req_i.req_type);
        state_o.phase = '0;
        state_o.step  = '0;
        state_o.held  = (req_i.req_type == OP_GOTO) ?
                        {1'b1, req_i.row_index, req_i.col_index} : req_i.byte_value;
      end
    end

    if (state_o.op != OP_IDLE) begin
      unique case (state_o.op)
        OP_INIT: begin
          t.st = state_o;
          if (state_o.step == '0) begin
            t.st.pins = '{en: 1'b1, rs: 1'b0, rw: 1'b0, nib: '0};
            t.st.step = 4'd1;
          end else if (state_o.step <= INIT_WAIT_LAST) begin
            t.st.step = state_o.step + 4'd1;
          end else if (state_o.step <= INIT_CMD_LAST) begin
            t = byte_tick(state_o, init_b, 1'b0);
            if (t.fin) begin
              t.st.step = state_o.step + 4'd1;
              t.fin     = 1'b0;
            end
          end else begin
            t.st.configured = 1'b1;
            t.st.step       = '0;
            t.fin           = 1'b1;
          end
        end
        OP_DATA: t = byte_tick(state_o, state_o.held, 1'b1);
        OP_CLEAR: begin
          if (state_o.step == CLR_FIRST) begin
            t = byte_tick(state_o, CLR_BYTE_A, 1'b0);
            if (t.fin) begin
              t.st.step = CLR_SECOND;
              t.fin     = 1'b0;
            end
          end else if (state_o.step == CLR_SECOND) begin
            t = byte_tick(state_o, CLR_BYTE_B, 1'b0);
            if (t.fin) begin
              t.st.step = CLR_FINISH;
              t.fin     = 1'b0;
            end
          end else begin
            t.st      = state_o;
            t.st.step = '0;
            t.fin     = 1'b1;
          end
        end
        default: t = byte_tick(state_o, state_o.held, 1'b0);
      endcase
      state_o = t.st;
      if (t.fin) begin
        res_o.done = 1'b1;
        state_o.op = OP_IDLE;
      end
    end

    res_o.pins = state_o.pins;
    res_o.busy = (state_o.op != OP_IDLE);
  end

endmodule

// ----- hw/rtl/char_lcd_nibble_sequencer.sv -----
// Top level of the tick-driven 4-bit character LCD sequencer.
//
// Usage:
//   req_i   carries one tick per request: req_type 0 is a plain tick, 1..5 also
//           start init, command byte, data byte, go-to or clear when idle.
//   res_o   returns one result per tick: E, RS, RW and D7..D4 levels after the
//           tick, busy, done and rejected flags.
//   cfg_i   writes rows_in_use (index 0) and cols_in_use (index 1); always
//           ready, write only while no request is in flight.
// Path: a request is taken into an input register, stepped through the
//   sequencer logic and its result is registered in the output register.
// Throughput: one request per cycle while res_o.ready stays high; the
//   sequencer state advances once per request in a single pass of short logic.
// Reset: sequencer idle, not configured, all pins low, rows_in_use 2 and
//   cols_in_use 16. No clearing pass.
// Stall: while res_o.ready is low the output register holds its result, the
//   input register holds the next request and req_i.ready drops once both
//   are full.
module char_lcd_nibble_sequencer import lcdns_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  lcdns_req_if.sink    req_i,
  lcdns_res_if.source  res_o,
  lcdns_cfg_if.sink    cfg_i
);

  logic             in_vld_q;
  req_t             in_q;
  logic             out_vld_q;
  res_t             out_q;
  state_t           state_q;
  state_t           state_d;
  res_t             res_d;
  logic [RowsW-1:0] rows_q;
  logic [ColW-1:0]  cols_q;
  logic             adv;
  logic             req_acc;

  // Advance the input register when the output register is free or drains
  assign adv     = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_acc = req_i.valid && req_i.ready;

  assign req_i.ready = !in_vld_q || adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      in_q <= '{req_type:   req_i.req_type,
                byte_value: req_i.byte_value,
                row_index:  req_i.row_index,
                col_index:  req_i.col_index};
    end
  end

  lcdns_step u_step (
    .state_i (state_q),
    .req_i   (in_q),
    .rows_i  (rows_q),
    .cols_i  (cols_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Commit the sequencer state only when the tick's result is captured
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: '0, step: '0, op: OP_IDLE, held: '0, configured: 1'b0,
                   pins: '0};
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ROWS: rows_q <= cfg_i.data[RowsW-1:0];
        CFG_COLS: cols_q <= cfg_i.data;
        default:  ;
      endcase
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.pin_enable    = out_q.pins.en;
  assign res_o.pin_select    = out_q.pins.rs;
  assign res_o.pin_readwrite = out_q.pins.rw;
  assign res_o.pin_nibble    = out_q.pins.nib;
  assign res_o.busy_res      = out_q.busy;
  assign res_o.done_res      = out_q.done;
  assign res_o.rejected      = out_q.rejected;

`ifndef ASSERT_OFF
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.done |-> !out_q.busy)
    else $error("done reported while still busy");

  a_rw_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !out_q.pins.rw)
    else $error("RW pin driven high");

  a_busy_rejects : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (state_q.op != OP_IDLE) && (in_q.req_type >= OP_INIT)
        && (in_q.req_type <= OP_CLEAR) |=> out_q.rejected)
    else $error("request accepted while busy");

  a_configured_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.configured |=> state_q.configured)
    else $error("configured flag dropped");
`endif

endmodule

// ----- sim/char_lcd_nibble_sequencer_tb.sv -----
// Self-checking testbench for the tick-driven character LCD nibble sequencer.
module char_lcd_nibble_sequencer_tb;
  import lcdns_pkg::*;

  // Stop the random part once this many ticks were sent, bounced ones included
  localparam int unsigned TARGET_TICKS   = 1400;
  // Drain and rewrite the panel geometry every this many ticks
  localparam int unsigned CFG_EVERY      = 300;
  // Length of each long receiver hold-off, long enough to back the block up
  localparam int unsigned HOLD_CYCLES    = 300;
  // Cycles without any handshake before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Margin after the final drain before the last check for missing results
  localparam int unsigned TAIL_CYCLES    = 4;
  localparam int unsigned MAX_REPORTS    = 40;

  // Request codes that start nothing
  localparam logic [ReqW-1:0] REQ_TICK     = OP_IDLE;
  localparam logic [ReqW-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [ReqW-1:0] REQ_SPARE_HI = 3'd7;

  // Power-up command bytes, first byte in the low lane
  localparam logic [7*ByteW-1:0] INIT_SEQ = {8'h10, 8'h00, 8'hC0, 8'h00, 8'h80, 8'h20, 8'h20};
  localparam int unsigned INIT_FIRST_STEP = 4;
  localparam logic [ByteW-1:0] CLEAR_FIRST  = 8'h00;
  localparam logic [ByteW-1:0] CLEAR_SECOND = 8'h01;

  // Tracks the sequencer state and keeps the pin frames each tick must produce.
  class lcd_pin_tracker;
    logic [PhaseW-1:0] phase;
    logic [StepW-1:0]  step;
    op_e               op;
    logic [ByteW-1:0]  held;
    bit                configured;
    pins_t             pins;
    logic [RowsW-1:0]  rows;
    logic [ColW-1:0]   cols;
    res_t              pin_frames_q[$];
    int                errors, noted, rejects, checked, dones, cfg_writes;
    int                starts [8];

    function new();
      phase      = '0;
      step       = '0;
      op         = OP_IDLE;
      held       = '0;
      configured = 1'b0;
      pins       = '0;
      rows       = ROWS_RESET;
      cols       = COLS_RESET;
      foreach (starts[i]) starts[i] = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      cfg_writes++;
      if (idx == CFG_ROWS) rows = value[RowsW-1:0];
      else cols = value[ColW-1:0];
    endfunction

    function bit busy();
      return op != OP_IDLE;
    endfunction

    function int pending();
      return pin_frames_q.size();
    endfunction

    // Every tick sent so far, bounced requests included
    function int taken();
      return noted;
    endfunction

    // Advance one byte transfer by a tick; return 1 on its final tick.
    function bit byte_phase(logic [ByteW-1:0] b, bit data_mode);
      phase = phase + 1'b1;
      if (phase == 4'd1) begin
        pins.rw  = 1'b0;
        pins.rs  = data_mode;
        pins.nib = b[7:4];
        pins.en  = 1'b0;
      end else if (phase == 4'd3) begin
        // Low nibble goes out only once the panel is in 4-bit mode, data always
        if (data_mode || configured) begin
          pins.nib = b[3:0];
          pins.en  = 1'b0;
        end else begin
          pins.en = 1'b1;
        end
      end else if (phase == 4'd5) begin
        pins.en = 1'b1;
        if (!data_mode) begin
          phase = '0;
          return 1'b1;
        end
      end else if (phase >= 4'd8) begin
        phase = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(req_t r);
      bit   fin;
      bit   rej;
      int   k;
      res_t frame;
      fin = 1'b0;
      rej = 1'b0;
      noted++;
      if (r.req_type >= OP_INIT && r.req_type <= OP_CLEAR) begin
        if (op != OP_IDLE) begin
          rej = 1'b1;
        end else if (r.req_type == OP_GOTO &&
                     (r.row_index >= rows || r.col_index >= cols)) begin
          rej = 1'b1;
        end else begin
          op    = op_e'(r.req_type);
          phase = '0;
          step  = '0;
          held  = (op == OP_GOTO) ? {1'b1, r.row_index, r.col_index} : r.byte_value;
          starts[int'(op)]++;
        end
      end
      if (rej) rejects++;

      case (op)
        OP_INIT: begin
          if (step == 0) begin
            pins.en  = 1'b1;
            pins.rw  = 1'b0;
            pins.rs  = 1'b0;
            pins.nib = '0;
            step     = 4'd1;
          end else if (step <= 3) begin
            step++;
          end else if (step <= 10) begin
            k = int'(step) - INIT_FIRST_STEP;
            if (byte_phase(INIT_SEQ[k*ByteW +: ByteW], 1'b0)) step++;
          end else begin
            configured = 1'b1;
            step       = '0;
            fin        = 1'b1;
          end
        end
        OP_DATA: fin = byte_phase(held, 1'b1);
        OP_CLEAR: begin
          if (step == 0) begin
            if (byte_phase(CLEAR_FIRST, 1'b0)) step = 4'd1;
          end else if (step == 1) begin
            if (byte_phase(CLEAR_SECOND, 1'b0)) step = 4'd2;
          end else begin
            step = '0;
            fin  = 1'b1;
          end
        end
        OP_CMD, OP_GOTO: fin = byte_phase(held, 1'b0);
        default: ;
      endcase

      if (fin) begin
        op = OP_IDLE;
        dones++;
      end
      frame.pins     = pins;
      frame.busy     = (op != OP_IDLE);
      frame.done     = fin;
      frame.rejected = rej;
      pin_frames_q.push_back(frame);
    endfunction

    function void cmp_field(string name, logic [3:0] got, logic [3:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is %0h, want %0h", checked, name, got, want));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pin_frames_q.size() == 0) begin
        report("result arrived with nothing expected");
        return;
      end
      want = pin_frames_q.pop_front();
      checked++;
      cmp_field("pin_enable", got.pins.en, want.pins.en);
      cmp_field("pin_select", got.pins.rs, want.pins.rs);
      cmp_field("pin_readwrite", got.pins.rw, want.pins.rw);
      cmp_field("pin_nibble", got.pins.nib, want.pins.nib);
      cmp_field("busy_res", got.busy, want.busy);
      cmp_field("done_res", got.done, want.done);
      cmp_field("rejected", got.rejected, want.rejected);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lcdns_req_if req_bus ();
  lcdns_res_if res_bus ();
  lcdns_cfg_if cfg_bus ();

  char_lcd_nibble_sequencer uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .res_o (res_bus),
    .cfg_i (cfg_bus)
  );

  lcd_pin_tracker tracker = new();

  // Idle stretches: toggled now and then so some bursts run back to back
  bit req_quiet;
  bit res_quiet;
  // Raised by the stimulus to ask the receiver for one long hold-off
  bit hold_off_req;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t make_req(logic [ReqW-1:0] kind, logic [ByteW-1:0] value,
                                    logic [RowW-1:0] row, logic [ColW-1:0] col);
    req_t r;
    r.req_type   = kind;
    r.byte_value = value;
    r.row_index  = row;
    r.col_index  = col;
    return r;
  endfunction

  function automatic req_t random_req(logic [ReqW-1:0] kind);
    return make_req(kind, ByteW'($urandom), RowW'($urandom_range(0, 1)),
                    ColW'($urandom_range(0, 63)));
  endfunction

  // Tick mostly sent while a request runs: mostly plain, sometimes a request
  // code that bounces while busy, sometimes an unused code.
  function automatic req_t filler_tick();
    req_t f;
    int   roll;
    f    = random_req(REQ_TICK);
    roll = $urandom_range(0, 99);
    if (roll >= 95)
      f.req_type = $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
    else if (roll >= 80)
      f.req_type = ReqW'($urandom_range(int'(OP_INIT), int'(OP_CLEAR)));
    return f;
  endfunction

  // Offer one request after a random gap; hold it until the block takes it.
  // Enter and leave on a falling edge.
  task automatic send_request(input req_t r);
    int n;
    if ($urandom_range(0, 29) == 0) req_quiet = !req_quiet;
    n = req_quiet ? 0 : pick_gap();
    if (n > 0) begin
      req_bus.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= r.req_type;
    req_bus.byte_value <= r.byte_value;
    req_bus.row_index  <= r.row_index;
    req_bus.col_index  <= r.col_index;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    tracker.note_request(r);
    @(negedge clk_i);
  endtask

  // Start a request and keep ticking until the sequencer should be idle again.
  task automatic run_op(input req_t r);
    send_request(r);
    while (tracker.busy()) send_request(filler_tick());
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(negedge clk_i); while (tracker.pending() != 0);
  endtask

  // Write both geometry registers back to back; only call when drained.
  task automatic write_geometry(input int rows, input int cols);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_ROWS;
    cfg_bus.data  <= CfgDataW'(rows);
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    tracker.write_reg(CFG_ROWS, CfgDataW'(rows));
    @(negedge clk_i);
    cfg_bus.index <= CFG_COLS;
    cfg_bus.data  <= CfgDataW'(cols);
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    tracker.write_reg(CFG_COLS, CfgDataW'(cols));
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Receiver: random stalls, quiet stretches and the requested long hold-off.
  initial begin : result_sink
    int n;
    res_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n            = HOLD_CYCLES;
      end else begin
        if ($urandom_range(0, 199) == 0) res_quiet = !res_quiet;
        n = res_quiet ? 0 : pick_gap();
      end
      if (n > 0) begin
        res_bus.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      res_bus.ready <= 1'b1;
    end
  end

  // Check every result taken at a rising edge against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    res_t got;
    if (rst_ni && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      got.pins.en  = res_bus.pin_enable;
      got.pins.rs  = res_bus.pin_select;
      got.pins.rw  = res_bus.pin_readwrite;
      got.pins.nib = res_bus.pin_nibble;
      got.busy     = res_bus.busy_res;
      got.done     = res_bus.done_res;
      got.rejected = res_bus.rejected;
      tracker.check_result(got);
    end
  end

  // Hang detector: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("no handshake for %0d cycles, %0d results outstanding",
                   idle_cycles, tracker.pending());
          $display("char_lcd_nibble_sequencer_tb: errors");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int  roll;
    int  cfg_round;
    int  next_cfg;
    bit  second_hold;
    req_t r;

    cfg_round          = 0;
    next_cfg           = CFG_EVERY;
    second_hold        = 1'b0;
    idle_cycles        = 0;
    req_quiet          = 1'b0;
    res_quiet          = 1'b0;
    hold_off_req       = 1'b0;
    rst_ni             = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_TICK;
    req_bus.byte_value = '0;
    req_bus.row_index  = '0;
    req_bus.col_index  = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_ROWS;
    cfg_bus.data       = '0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, reset geometry of two rows by sixteen columns.
    // Plain tick and the two unused codes: nothing starts, nothing bounces.
    send_request(make_req(REQ_TICK, 8'h00, 1'b0, 6'd0));
    send_request(make_req(REQ_SPARE_LO, 8'hFF, 1'b1, 6'd63));
    send_request(make_req(REQ_SPARE_HI, 8'h00, 1'b0, 6'd0));
    // Before init: command holds E high instead of the low nibble, data does not
    run_op(make_req(OP_CMD, 8'hA5, 1'b0, 6'd0));
    run_op(make_req(OP_DATA, 8'h3C, 1'b0, 6'd0));
    // Go-to at the last legal spot, then off the right edge and far out
    run_op(make_req(OP_GOTO, 8'h00, 1'b1, 6'd15));
    run_op(make_req(OP_GOTO, 8'h00, 1'b1, 6'd16));
    run_op(make_req(OP_GOTO, 8'hFF, 1'b0, 6'd63));
    run_op(make_req(OP_CLEAR, 8'h00, 1'b0, 6'd0));
    run_op(make_req(OP_INIT, 8'h00, 1'b0, 6'd0));
    // Configured now: both nibbles go out
    run_op(make_req(OP_CMD, 8'h00, 1'b0, 6'd0));
    run_op(make_req(OP_CMD, 8'hFF, 1'b1, 6'd63));
    run_op(make_req(OP_DATA, 8'hFF, 1'b0, 6'd0));
    run_op(make_req(OP_DATA, 8'h00, 1'b1, 6'd0));
    run_op(make_req(OP_GOTO, 8'h00, 1'b0, 6'd0));
    // Init while already configured runs the whole sequence again
    run_op(make_req(OP_INIT, 8'hFF, 1'b0, 6'd0));

    // Single row, widest panel
    drain();
    write_geometry(1, 40);
    run_op(make_req(OP_GOTO, 8'h00, 1'b1, 6'd0));
    run_op(make_req(OP_GOTO, 8'h00, 1'b0, 6'd39));
    run_op(make_req(OP_GOTO, 8'h00, 1'b0, 6'd40));

    // Two rows, one column
    drain();
    write_geometry(2, 1);
    run_op(make_req(OP_GOTO, 8'h00, 1'b1, 6'd0));
    run_op(make_req(OP_GOTO, 8'h00, 1'b1, 6'd1));

    // Random part: mostly complete requests with random content, some noise.
    // Back the block up early on with a long receiver hold-off.
    hold_off_req = 1'b1;
    while (tracker.taken() < TARGET_TICKS) begin
      if (tracker.taken() >= next_cfg) begin
        // Pause the sender until everything is back, then reshape the panel
        drain();
        case (cfg_round % 5)
          0:       write_geometry(1, 1);
          1:       write_geometry(2, 40);
          2:       write_geometry(1, 40);
          3:       write_geometry(2, 1);
          default: write_geometry($urandom_range(1, 2), $urandom_range(1, 40));
        endcase
        cfg_round++;
        next_cfg += CFG_EVERY;
      end
      if (!second_hold && tracker.taken() >= TARGET_TICKS / 2) begin
        second_hold  = 1'b1;
        hold_off_req = 1'b1;
      end

      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        send_request(filler_tick());
      end else if (roll < 30) begin
        run_op(random_req(OP_CMD));
      end else if (roll < 55) begin
        run_op(random_req(OP_DATA));
      end else if (roll < 80) begin
        r = random_req(OP_GOTO);
        // Most columns inside the panel, the rest anywhere the field reaches
        if ($urandom_range(0, 99) < 75)
          r.col_index = ColW'($urandom_range(0, int'(tracker.cols) - 1));
        run_op(r);
      end else if (roll < 93) begin
        run_op(random_req(OP_CLEAR));
      end else if (roll < 97) begin
        run_op(random_req(OP_INIT));
      end else begin
        // Noise: a short burst of any code, busy or not
        repeat ($urandom_range(1, 6))
          send_request(random_req(ReqW'($urandom_range(0, 7))));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d expected results never arrived", tracker.pending()));

    $display("ran %0d ticks (%0d bounced), checked %0d results, %0d register writes",
             tracker.noted, tracker.rejects, tracker.checked, tracker.cfg_writes);
    $display("started init %0d, command %0d, data %0d, go-to %0d, clear %0d; %0d finished",
             tracker.starts[int'(OP_INIT)], tracker.starts[int'(OP_CMD)],
             tracker.starts[int'(OP_DATA)], tracker.starts[int'(OP_GOTO)],
             tracker.starts[int'(OP_CLEAR)], tracker.dones);
    if (tracker.errors == 0)
      $display("char_lcd_nibble_sequencer_tb: clean");
    else
      $display("char_lcd_nibble_sequencer_tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lcdns_pkg.sv
hw/rtl/lcdns_if.sv
hw/rtl/lcdns_step.sv
hw/rtl/char_lcd_nibble_sequencer.sv
sim/char_lcd_nibble_sequencer_tb.sv
